// File: src/sphere_frustum_cull_macros.svh
// Assertion macros shared by the culling block.
`ifndef SPHERE_FRUSTUM_CULL_MACROS_SVH
`define SPHERE_FRUSTUM_CULL_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sphere_frustum_cull: same-cycle check failed");
// Next-cycle implication.
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sphere_frustum_cull: next-cycle check failed");
`else
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/sfc_pkg.sv
package sfc_pkg;

	localparam int COORD_W = 16;
	localparam int RAD_W   = 15;
	localparam int DIST_W  = 16;
	localparam int VEC_W   = 3 * COORD_W;
	localparam int OFS_W   = COORD_W + 1;
	localparam int PROD_W  = OFS_W + COORD_W;
	localparam int DOT_W   = PROD_W + 2;
	localparam int LIM_W   = DIST_W + 2;
	localparam int FRAC_SH = 14;
	localparam int CMP_W   = DOT_W + 1;
	localparam int IDX_W   = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_CAMERA = 3'd0,
		REG_AXIS   = 3'd1,
		REG_LEFT   = 3'd2,
		REG_RIGHT  = 3'd3,
		REG_TOP    = 3'd4,
		REG_BOTTOM = 3'd5,
		REG_NEAR   = 3'd6,
		REG_FAR    = 3'd7
	} cfg_reg_t;

	localparam logic [DIST_W-1:0] FAR_RESET = '1;

	// Per-sphere limits in Q14.4, carried alongside the dot products.
	typedef struct packed {
		logic signed [LIM_W-1:0] near_lim;
		logic signed [LIM_W-1:0] far_lim;
		logic [RAD_W-1:0]        rad;
	} thr_t;

endpackage

// File: src/sfc_offset.sv
module sfc_offset import sfc_pkg::*; (
	input  logic                       clk,
	input  logic                       en,
	input  logic signed [COORD_W-1:0]  center_x,
	input  logic signed [COORD_W-1:0]  center_y,
	input  logic signed [COORD_W-1:0]  center_z,
	input  logic [RAD_W-1:0]           radius,
	input  logic [VEC_W-1:0]           camera,
	input  logic [DIST_W-1:0]          near_dist,
	input  logic [DIST_W-1:0]          far_dist,
	output logic signed [OFS_W-1:0]    dx_s1,
	output logic signed [OFS_W-1:0]    dy_s1,
	output logic signed [OFS_W-1:0]    dz_s1,
	output thr_t                       thr_s1
);

	logic signed [COORD_W-1:0] cam_x, cam_y, cam_z;

	assign cam_x = camera[COORD_W-1:0];
	assign cam_y = camera[2*COORD_W-1:COORD_W];
	assign cam_z = camera[3*COORD_W-1:2*COORD_W];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= OFS_W'(center_x) - OFS_W'(cam_x);
			dy_s1 <= OFS_W'(center_y) - OFS_W'(cam_y);
			dz_s1 <= OFS_W'(center_z) - OFS_W'(cam_z);
			thr_s1.near_lim <= $signed(LIM_W'(near_dist)) + $signed(LIM_W'(radius));
			// A radius beyond the far distance drives this limit negative.
			thr_s1.far_lim <= $signed(LIM_W'(far_dist)) - $signed(LIM_W'(radius));
			thr_s1.rad <= radius;
		end
	end

endmodule

// File: src/sfc_dot.sv
module sfc_dot import sfc_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [OFS_W-1:0]  dx,
	input  logic signed [OFS_W-1:0]  dy,
	input  logic signed [OFS_W-1:0]  dz,
	input  logic [VEC_W-1:0]         vec,
	output logic signed [DOT_W-1:0]  dot_s3
);

	logic signed [COORD_W-1:0] vx, vy, vz;
	logic signed [PROD_W-1:0]  px_s2, py_s2, pz_s2;

	assign vx = vec[COORD_W-1:0];
	assign vy = vec[2*COORD_W-1:COORD_W];
	assign vz = vec[3*COORD_W-1:2*COORD_W];

	always_ff @(posedge clk) begin
		if (en) begin
			px_s2 <= dx * vx;
			py_s2 <= dy * vy;
			pz_s2 <= dz * vz;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3 <= DOT_W'(px_s2) + DOT_W'(py_s2) + DOT_W'(pz_s2);
		end
	end

endmodule

// File: src/sphere_frustum_cull.sv
// Bounding-sphere view-frustum culling, one sphere per request.
// Input stream: s_tvalid/s_tready/s_tdata carry the sphere centre and radius.
// Output stream: m_tvalid/m_tready/m_tdata carry the visible flag in bit 0.
// Configuration: cfg_we writes cfg_data into the register selected by cfg_index
// (camera position, view axis, four side normals, near and far distance);
// write only while no sphere is in flight.
// Four register stages: offset from the camera, products, dot sums, plane tests.
// A result is offered once its request has passed the offset, product, dot-sum
// and plane-test registers in turn, with m_tvalid taken from the last stage.
// A new sphere is accepted every cycle while the output is free or being taken.
// The whole pipeline advances on one enable; when the receiver holds m_tready
// low with a result waiting, every stage freezes and s_tready drops, so nothing
// is lost or repeated. Throughput is then set by the receiver alone.
// Reset clears the valid bits and returns the configuration registers to zero,
// except the far distance, which returns to its maximum.
`include "sphere_frustum_cull_macros.svh"

module sphere_frustum_cull import sfc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [63:0]         s_tdata,  // center_x, center_y, center_z, radius, zero pad
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,  // visible, zero pad
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [VEC_W-1:0]    cfg_data
);

	logic [VEC_W-1:0]  camera_q, axis_q, left_q, right_q, top_q, bottom_q;
	logic [DIST_W-1:0] near_dist_q, far_dist_q;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic visible_s4;

	logic signed [OFS_W-1:0] dx_s1, dy_s1, dz_s1;
	thr_t thr_s1, thr_s2, thr_s3;
	logic signed [DOT_W-1:0] axis_dot, left_dot, right_dot, top_dot, bottom_dot;

	logic signed [CMP_W-1:0] near_q18, far_q18, rad_q18;
	logic signed [CMP_W-1:0] axis_c, left_c, right_c, top_c, bottom_c;
	logic cull;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_q    <= '0;
			axis_q      <= '0;
			left_q      <= '0;
			right_q     <= '0;
			top_q       <= '0;
			bottom_q    <= '0;
			near_dist_q <= '0;
			far_dist_q  <= FAR_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_CAMERA: camera_q    <= cfg_data;
				REG_AXIS:   axis_q      <= cfg_data;
				REG_LEFT:   left_q      <= cfg_data;
				REG_RIGHT:  right_q     <= cfg_data;
				REG_TOP:    top_q       <= cfg_data;
				REG_BOTTOM: bottom_q    <= cfg_data;
				REG_NEAR:   near_dist_q <= cfg_data[DIST_W-1:0];
				REG_FAR:    far_dist_q  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv      = !vld_s4 || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	sfc_offset u_offset (
		.clk       (clk),
		.en        (adv),
		.center_x  (s_tdata[15:0]),
		.center_y  (s_tdata[31:16]),
		.center_z  (s_tdata[47:32]),
		.radius    (s_tdata[62:48]),
		.camera    (camera_q),
		.near_dist (near_dist_q),
		.far_dist  (far_dist_q),
		.dx_s1     (dx_s1),
		.dy_s1     (dy_s1),
		.dz_s1     (dz_s1),
		.thr_s1    (thr_s1)
	);

	sfc_dot u_dot_axis (
		.clk(clk), .en(adv), .dx(dx_s1), .dy(dy_s1), .dz(dz_s1), .vec(axis_q),
		.dot_s3(axis_dot)
	);
	sfc_dot u_dot_left (
		.clk(clk), .en(adv), .dx(dx_s1), .dy(dy_s1), .dz(dz_s1), .vec(left_q),
		.dot_s3(left_dot)
	);
	sfc_dot u_dot_right (
		.clk(clk), .en(adv), .dx(dx_s1), .dy(dy_s1), .dz(dz_s1), .vec(right_q),
		.dot_s3(right_dot)
	);
	sfc_dot u_dot_top (
		.clk(clk), .en(adv), .dx(dx_s1), .dy(dy_s1), .dz(dz_s1), .vec(top_q),
		.dot_s3(top_dot)
	);
	sfc_dot u_dot_bottom (
		.clk(clk), .en(adv), .dx(dx_s1), .dy(dy_s1), .dz(dz_s1), .vec(bottom_q),
		.dot_s3(bottom_dot)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			thr_s2 <= thr_s1;
			thr_s3 <= thr_s2;
		end
	end

	// Limits are Q14.4 and the dot products Q.18, so the limits move up by 14 bits.
	assign near_q18 = CMP_W'($signed({thr_s3.near_lim, {FRAC_SH{1'b0}}}));
	assign far_q18  = CMP_W'($signed({thr_s3.far_lim, {FRAC_SH{1'b0}}}));
	assign rad_q18  = $signed(CMP_W'({thr_s3.rad, {FRAC_SH{1'b0}}}));

	assign axis_c   = CMP_W'(axis_dot);
	assign left_c   = CMP_W'(left_dot);
	assign right_c  = CMP_W'(right_dot);
	assign top_c    = CMP_W'(top_dot);
	assign bottom_c = CMP_W'(bottom_dot);

	always_comb begin
		cull = (axis_c < near_q18) || (axis_c > far_q18)
			|| (left_c < -rad_q18) || (right_c < -rad_q18)
			|| (top_c > rad_q18) || (bottom_c > rad_q18);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			visible_s4 <= !cull;
		end
	end

	assign m_tvalid = vld_s4;
	assign m_tdata  = {7'd0, visible_s4};

	`SFC_ASSERT_NEXT(a_last_stage_fills, clk, arst_n, vld_s3 && adv, m_tvalid)
	`SFC_ASSERT_NEXT(a_stall_freezes, clk, arst_n, !adv,
		$stable(vld_s1) && $stable(vld_s2) && $stable(vld_s3) && $stable(vld_s4))
	`SFC_ASSERT_NEXT(a_result_holds, clk, arst_n, m_tvalid && !m_tready,
		$stable(visible_s4))

endmodule
